/* rtl/twsrm_pkg.sv */
package twsrm_pkg;

   localparam int unsigned CFG_WIDTH  = 16;
   localparam int unsigned DATA_WIDTH = 8;
   localparam int unsigned ADDR_WIDTH = 7;
   localparam int unsigned CSR_AW     = 3;

   localparam logic [DATA_WIDTH-1:0] WRITE_FLAG  = 8'h80;
   localparam logic [CFG_WIDTH-1:0]  HALF_RESET  = 16'd1;
   localparam logic [CFG_WIDTH-1:0]  TURN_RESET  = 16'd100;

   typedef enum logic {
      REG_HALF_PERIOD = 1'b0,
      REG_TURNAROUND  = 1'b1
   } reg_index_type;

   typedef enum logic {
      ACT_READ  = 1'b0,
      ACT_WRITE = 1'b1
   } action_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] half_period_ticks;
      logic [CFG_WIDTH-1:0] turnaround_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  sclk;
      logic                  sdio_out;
      logic                  sdio_oe;
      logic                  busy_res;
      logic                  done_res;
      logic [DATA_WIDTH-1:0] read_data;
   } result_type;

endpackage

/* rtl/twsrm_req_if.sv */
interface twsrm_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic       action;
   logic [6:0] reg_addr;
   logic [7:0] write_data;
   logic       sdio_in;

   modport source (
      output valid, start_req, action, reg_addr, write_data, sdio_in,
      input  ready
   );
   modport sink (
      input  valid, start_req, action, reg_addr, write_data, sdio_in,
      output ready
   );
endinterface

/* rtl/twsrm_rsp_if.sv */
interface twsrm_rsp_if;
   logic       valid;
   logic       ready;
   logic       sclk;
   logic       sdio_out;
   logic       sdio_oe;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;

   modport source (
      output valid, sclk, sdio_out, sdio_oe, busy_res, done_res, read_data,
      input  ready
   );
   modport sink (
      input  valid, sclk, sdio_out, sdio_oe, busy_res, done_res, read_data,
      output ready
   );
endinterface

/* rtl/twsrm_csr.sv */
module twsrm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [twsrm_pkg::CSR_AW-1:0]    paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output twsrm_pkg::cfg_type              cfg
);

   logic [twsrm_pkg::CFG_WIDTH-1:0] half_ff;
   logic [twsrm_pkg::CFG_WIDTH-1:0] half_in;
   logic [twsrm_pkg::CFG_WIDTH-1:0] turn_ff;
   logic [twsrm_pkg::CFG_WIDTH-1:0] turn_in;
   logic                            wr_en;
   twsrm_pkg::reg_index_type        sel;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign sel    = twsrm_pkg::reg_index_type'(paddr[2]);

   always_comb begin
      half_in = half_ff;
      turn_in = turn_ff;
      if (wr_en) begin
         case (sel)
            twsrm_pkg::REG_HALF_PERIOD: half_in = pwdata[twsrm_pkg::CFG_WIDTH-1:0];
            twsrm_pkg::REG_TURNAROUND:  turn_in = pwdata[twsrm_pkg::CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         twsrm_pkg::REG_HALF_PERIOD: prdata = {16'd0, half_ff};
         twsrm_pkg::REG_TURNAROUND:  prdata = {16'd0, turn_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= twsrm_pkg::HALF_RESET;
         turn_ff <= twsrm_pkg::TURN_RESET;
      end else begin
         half_ff <= half_in;
         turn_ff <= turn_in;
      end
   end

   assign cfg.half_period_ticks = half_ff;
   assign cfg.turnaround_ticks  = turn_ff;

endmodule

/* rtl/twsrm_engine.sv */
module twsrm_engine #(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  twsrm_pkg::cfg_type    cfg,
   input  logic                  start_req,
   input  logic                  action,
   input  logic [6:0]            reg_addr,
   input  logic [7:0]            write_data,
   input  logic                  sdio_in,
   output twsrm_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_SETUP = 4'd1,
      PH_APRE  = 4'd2,
      PH_ALOW  = 4'd3,
      PH_AHIGH = 4'd4,
      PH_TURN  = 4'd5,
      PH_DLOW  = 4'd6,
      PH_DHIGH = 4'd7,
      PH_DHOLD = 4'd8
   } phase_type;

   localparam logic [32:0] TIMER_TOP = (33'd1 << TIMER_WIDTH) - 33'd1;

   phase_type             phase_ff, phase_in;
   logic [2:0]            bit_ff, bit_in;
   logic [TIMER_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  is_write_ff, is_write_in;
   logic [7:0]            held_ff, held_in;
   logic [7:0]            latch_ff, latch_in;
   logic                  second_ff, second_in;
   logic                  clk_ff, clk_in;
   logic                  drv_ff, drv_in;
   logic                  oe_ff, oe_in;
   logic                  done;
   logic [TIMER_WIDTH-1:0] half_span;
   logic [TIMER_WIDTH-1:0] turn_span;

   function automatic logic [TIMER_WIDTH-1:0] span(input logic [15:0] v);
      logic [32:0] t;
      t = (v == 16'd0) ? 33'd1 : {17'd0, v};
      if (t > TIMER_TOP) begin
         span = TIMER_TOP[TIMER_WIDTH-1:0];
      end else begin
         span = t[TIMER_WIDTH-1:0];
      end
   endfunction

   assign half_span = span(cfg.half_period_ticks);
   assign turn_span = span(cfg.turnaround_ticks);

   always_comb begin
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      wait_in     = wait_ff;
      shift_in    = shift_ff;
      is_write_in = is_write_ff;
      held_in     = held_ff;
      latch_in    = latch_ff;
      second_in   = second_ff;
      clk_in      = clk_ff;
      drv_in      = drv_ff;
      oe_in       = oe_ff;
      done        = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (start_req) begin
            is_write_in = action;
            bit_in      = 3'd7;
            second_in   = 1'b0;
            latch_in    = write_data;
            wait_in     = half_span;
            if (twsrm_pkg::action_type'(action) == twsrm_pkg::ACT_WRITE) begin
               shift_in = {1'b0, reg_addr} | twsrm_pkg::WRITE_FLAG;
               clk_in   = 1'b0;
               phase_in = PH_APRE;
            end else begin
               shift_in = {1'b0, reg_addr};
               clk_in   = 1'b1;
               oe_in    = 1'b1;
               drv_in   = 1'b1;
               phase_in = PH_SETUP;
            end
         end
      end else if (wait_ff > TIMER_WIDTH'(1)) begin
         wait_in = wait_ff - TIMER_WIDTH'(1);
      end else begin
         case (phase_ff)
            PH_SETUP: begin
               clk_in  = 1'b0;
               wait_in = half_span;
               if (is_write_ff) begin
                  phase_in = PH_APRE;
               end else begin
                  drv_in   = shift_ff[bit_ff];
                  phase_in = PH_ALOW;
               end
            end
            PH_APRE: begin
               oe_in    = 1'b1;
               drv_in   = shift_ff[bit_ff];
               phase_in = PH_ALOW;
               wait_in  = half_span;
            end
            PH_ALOW: begin
               clk_in   = 1'b1;
               phase_in = PH_AHIGH;
               wait_in  = half_span;
            end
            PH_AHIGH: begin
               if (bit_ff != 3'd0) begin
                  bit_in  = bit_ff - 3'd1;
                  clk_in  = 1'b0;
                  wait_in = half_span;
                  if (is_write_ff) begin
                     phase_in = PH_APRE;
                  end else begin
                     drv_in   = shift_ff[bit_ff - 3'd1];
                     phase_in = PH_ALOW;
                  end
               end else if (is_write_ff) begin
                  if (!second_ff) begin
                     second_in = 1'b1;
                     shift_in  = latch_ff;
                     bit_in    = 3'd7;
                     clk_in    = 1'b0;
                     wait_in   = half_span;
                     phase_in  = PH_APRE;
                  end else begin
                     phase_in = PH_IDLE;
                     wait_in  = '0;
                     clk_in   = 1'b1;
                     oe_in    = 1'b0;
                     done     = 1'b1;
                  end
               end else begin
                  oe_in    = 1'b0;
                  phase_in = PH_TURN;
                  wait_in  = turn_span;
               end
            end
            PH_TURN: begin
               bit_in   = 3'd7;
               shift_in = 8'd0;
               clk_in   = 1'b0;
               phase_in = PH_DLOW;
               wait_in  = half_span;
            end
            PH_DLOW: begin
               clk_in   = 1'b1;
               phase_in = PH_DHIGH;
               wait_in  = half_span;
            end
            PH_DHIGH: begin
               shift_in = {shift_ff[6:0], sdio_in};
               phase_in = PH_DHOLD;
               wait_in  = half_span;
            end
            PH_DHOLD: begin
               if (bit_ff != 3'd0) begin
                  bit_in   = bit_ff - 3'd1;
                  clk_in   = 1'b0;
                  phase_in = PH_DLOW;
                  wait_in  = half_span;
               end else begin
                  held_in  = shift_ff;
                  phase_in = PH_IDLE;
                  wait_in  = '0;
                  clk_in   = 1'b1;
                  oe_in    = 1'b0;
                  done     = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               wait_in  = '0;
               clk_in   = 1'b1;
               oe_in    = 1'b0;
            end
         endcase
      end
   end

   assign result.sclk      = clk_in;
   assign result.sdio_out  = oe_in ? drv_in : 1'b1;
   assign result.sdio_oe   = oe_in;
   assign result.busy_res  = (phase_in != PH_IDLE);
   assign result.done_res  = done;
   assign result.read_data = held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_ff      <= 3'd0;
         wait_ff     <= '0;
         shift_ff    <= 8'd0;
         is_write_ff <= 1'b0;
         held_ff     <= 8'd0;
         latch_ff    <= 8'd0;
         second_ff   <= 1'b0;
         clk_ff      <= 1'b1;
         drv_ff      <= 1'b1;
         oe_ff       <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         bit_ff      <= bit_in;
         wait_ff     <= wait_in;
         shift_ff    <= shift_in;
         is_write_ff <= is_write_in;
         held_ff     <= held_in;
         latch_ff    <= latch_in;
         second_ff   <= second_in;
         clk_ff      <= clk_in;
         drv_ff      <= drv_in;
         oe_ff       <= oe_in;
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      step && done |=> phase_ff == PH_IDLE && !oe_ff && clk_ff)
      else $error("access ended but engine not idle");

   a_busy_timer: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> wait_ff != '0)
      else $error("active phase with empty timer");

   a_turn_released: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TURN |-> !oe_ff)
      else $error("data line driven during turnaround");

   a_dlow_clock: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DLOW |-> !clk_ff && !oe_ff)
      else $error("bad levels in data low phase");

endmodule

/* rtl/two_wire_sensor_register_master_top.sv */
// Two-wire sensor register master. Each req transaction is one timing tick and
// yields exactly one rsp transaction with the clock/data line levels, busy,
// done and the last read byte as they stand after that tick. A tick is handled
// by the phase engine, so one transaction is accepted every cycle unless the
// input is stalled; the single result register only stalls the input while it
// holds a result that rsp has not taken. Phase lengths come from the two CSRs
// (0 counts as 1) and saturate at 2**TIMER_WIDTH - 1 ticks.
module two_wire_sensor_register_master_top #(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   twsrm_req_if.sink                    req_chan,
   twsrm_rsp_if.source                  rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [twsrm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   twsrm_pkg::cfg_type    cfg;
   twsrm_pkg::result_type result;
   twsrm_pkg::result_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  step;

   twsrm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   twsrm_engine #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cfg        (cfg),
      .start_req  (req_chan.start_req),
      .action     (req_chan.action),
      .reg_addr   (req_chan.reg_addr),
      .write_data (req_chan.write_data),
      .sdio_in    (req_chan.sdio_in),
      .result     (result)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.sclk      = rsp_ff.sclk;
   assign rsp_chan.sdio_out  = rsp_ff.sdio_out;
   assign rsp_chan.sdio_oe   = rsp_ff.sdio_oe;
   assign rsp_chan.busy_res  = rsp_ff.busy_res;
   assign rsp_chan.done_res  = rsp_ff.done_res;
   assign rsp_chan.read_data = rsp_ff.read_data;

   a_step_loads: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted transaction did not load result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !step)
      else $error("pending result overwritten");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while busy");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned TIMER_W = 16;

   typedef enum logic [3:0] {
      BUS_IDLE,
      BUS_SETUP,
      BUS_ADDR_PRE,
      BUS_ADDR_LOW,
      BUS_ADDR_HIGH,
      BUS_TURN,
      BUS_DATA_LOW,
      BUS_DATA_HIGH,
      BUS_DATA_HOLD
   } bus_phase_type;

   typedef struct packed {
      logic                             start_req;
      twsrm_pkg::action_type            action;
      logic [twsrm_pkg::ADDR_WIDTH-1:0] reg_addr;
      logic [twsrm_pkg::DATA_WIDTH-1:0] write_data;
      logic                             sdio_in;
   } tick_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [twsrm_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0]                  csr_pwdata;
   logic [31:0]                  csr_prdata;
   logic                         csr_pready;

   twsrm_req_if req_bus ();
   twsrm_rsp_if rsp_bus ();

   two_wire_sensor_register_master_top #(.TIMER_WIDTH(TIMER_W)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bus state as predicted from accepted ticks
   logic [twsrm_pkg::CFG_WIDTH-1:0]  half_ticks = twsrm_pkg::HALF_RESET;
   logic [twsrm_pkg::CFG_WIDTH-1:0]  turn_ticks = twsrm_pkg::TURN_RESET;
   bus_phase_type                    bus_phase = BUS_IDLE;
   logic [2:0]                       bit_sel = '0;
   int unsigned                      ticks_left = 0;
   logic [twsrm_pkg::DATA_WIDTH-1:0] shift_reg = '0;
   logic                             wr_mode = 1'b0;
   logic [twsrm_pkg::DATA_WIDTH-1:0] last_read = '0;
   logic [twsrm_pkg::DATA_WIDTH-1:0] wr_byte = '0;
   logic                             second_byte = 1'b0;
   logic                             clk_lvl = 1'b1;
   logic                             drv_lvl = 1'b1;
   logic                             drv_en = 1'b0;

   twsrm_pkg::result_type expected_levels[$];
   int unsigned mismatches = 0;
   int unsigned tb_errors = 0;
   int unsigned tick_total = 0;
   int unsigned done_total = 0;
   int unsigned reads_started = 0;
   int unsigned writes_started = 0;
   int unsigned csr_updates = 0;
   bit          gaps_on = 1'b0;
   bit          rsp_stalls = 1'b0;
   int unsigned rsp_hold = 0;

   function automatic int unsigned span(input logic [twsrm_pkg::CFG_WIDTH-1:0] v);
      longint unsigned top;
      longint unsigned t;
      top = (64'd1 << TIMER_W) - 64'd1;
      t = (v == '0) ? 64'd1 : 64'(v);
      return (t > top) ? 32'(top) : 32'(t);
   endfunction

   task enter_phase(input bus_phase_type p, input logic [twsrm_pkg::CFG_WIDTH-1:0] len);
      bus_phase = p;
      ticks_left = span(len);
   endtask

   task next_addr_bit();
      clk_lvl = 1'b0;
      if (wr_mode) begin
         enter_phase(BUS_ADDR_PRE, half_ticks);
      end else begin
         drv_lvl = shift_reg[bit_sel];
         enter_phase(BUS_ADDR_LOW, half_ticks);
      end
   endtask

   task end_access(output logic done);
      bus_phase = BUS_IDLE;
      ticks_left = 0;
      clk_lvl = 1'b1;
      drv_en = 1'b0;
      done = 1'b1;
   endtask

   task step_bus(input tick_type t, output twsrm_pkg::result_type r);
      logic done;
      done = 1'b0;
      if (bus_phase == BUS_IDLE) begin
         if (t.start_req) begin
            wr_mode = (t.action == twsrm_pkg::ACT_WRITE);
            bit_sel = 3'd7;
            second_byte = 1'b0;
            wr_byte = t.write_data;
            if (wr_mode) begin
               writes_started++;
               shift_reg = {1'b0, t.reg_addr} | twsrm_pkg::WRITE_FLAG;
               clk_lvl = 1'b0;
               enter_phase(BUS_ADDR_PRE, half_ticks);
            end else begin
               reads_started++;
               shift_reg = {1'b0, t.reg_addr};
               clk_lvl = 1'b1;
               drv_en = 1'b1;
               drv_lvl = 1'b1;
               enter_phase(BUS_SETUP, half_ticks);
            end
         end
      end else if (ticks_left > 1) begin
         ticks_left--;
      end else begin
         case (bus_phase)
            BUS_SETUP: next_addr_bit();
            BUS_ADDR_PRE: begin
               drv_en = 1'b1;
               drv_lvl = shift_reg[bit_sel];
               enter_phase(BUS_ADDR_LOW, half_ticks);
            end
            BUS_ADDR_LOW: begin
               clk_lvl = 1'b1;
               enter_phase(BUS_ADDR_HIGH, half_ticks);
            end
            BUS_ADDR_HIGH: begin
               if (bit_sel > 0) begin
                  bit_sel--;
                  next_addr_bit();
               end else if (wr_mode) begin
                  if (!second_byte) begin
                     second_byte = 1'b1;
                     shift_reg = wr_byte;
                     bit_sel = 3'd7;
                     next_addr_bit();
                  end else begin
                     end_access(done);
                  end
               end else begin
                  drv_en = 1'b0;
                  enter_phase(BUS_TURN, turn_ticks);
               end
            end
            BUS_TURN: begin
               bit_sel = 3'd7;
               shift_reg = '0;
               clk_lvl = 1'b0;
               enter_phase(BUS_DATA_LOW, half_ticks);
            end
            BUS_DATA_LOW: begin
               clk_lvl = 1'b1;
               enter_phase(BUS_DATA_HIGH, half_ticks);
            end
            BUS_DATA_HIGH: begin
               shift_reg = {shift_reg[twsrm_pkg::DATA_WIDTH-2:0], t.sdio_in};
               enter_phase(BUS_DATA_HOLD, half_ticks);
            end
            BUS_DATA_HOLD: begin
               if (bit_sel > 0) begin
                  bit_sel--;
                  clk_lvl = 1'b0;
                  enter_phase(BUS_DATA_LOW, half_ticks);
               end else begin
                  last_read = shift_reg;
                  end_access(done);
               end
            end
            default: begin
               bus_phase = BUS_IDLE;
               ticks_left = 0;
               clk_lvl = 1'b1;
               drv_en = 1'b0;
            end
         endcase
      end
      if (done)
         done_total++;
      r.sclk = clk_lvl;
      r.sdio_out = drv_en ? drv_lvl : 1'b1;
      r.sdio_oe = drv_en;
      r.busy_res = (bus_phase != BUS_IDLE);
      r.done_res = done;
      r.read_data = last_read;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      tick_type              seen;
      twsrm_pkg::result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen = '{req_bus.start_req, twsrm_pkg::action_type'(req_bus.action),
                     req_bus.reg_addr, req_bus.write_data, req_bus.sdio_in};
            step_bus(seen, want);
            expected_levels.push_back(want);
            tick_total++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_levels.size() == 0) begin
               $error("bus levels returned with no tick pending");
               mismatches++;
            end else begin
               want = expected_levels.pop_front();
               check_field("sclk", 8'(want.sclk), 8'(rsp_bus.sclk));
               check_field("sdio_out", 8'(want.sdio_out), 8'(rsp_bus.sdio_out));
               check_field("sdio_oe", 8'(want.sdio_oe), 8'(rsp_bus.sdio_oe));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_bus.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_bus.done_res));
               check_field("read_data", want.read_data, rsp_bus.read_data);
            end
         end
      end
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
         rsp_hold = pick_gap() - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // called and returns at a falling edge
   task send_tick(input tick_type t);
      int unsigned gap;
      gap = (gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.start_req  <= t.start_req;
      req_bus.action     <= t.action;
      req_bus.reg_addr   <= t.reg_addr;
      req_bus.write_data <= t.write_data;
      req_bus.sdio_in    <= t.sdio_in;
      req_bus.valid      <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   function automatic tick_type random_tick();
      tick_type t;
      t.start_req = (bus_phase == BUS_IDLE) ? ($urandom_range(0, 4) != 0)
                                            : ($urandom_range(0, 3) == 0);
      t.action = twsrm_pkg::action_type'(1'($urandom_range(0, 1)));
      t.reg_addr = 7'($urandom_range(0, 127));
      t.write_data = 8'($urandom_range(0, 255));
      t.sdio_in = 1'($urandom_range(0, 1));
      return t;
   endfunction

   task settle_bus();
      req_bus.valid <= 1'b0;
      while (expected_levels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task finish_access();
      tick_type t;
      while (bus_phase != BUS_IDLE) begin
         t = random_tick();
         t.start_req = 1'b0;
         send_tick(t);
      end
   endtask

   // the pattern drives sdio_in for the bit being clocked in, so a read returns it
   task run_access(input twsrm_pkg::action_type act,
                   input logic [twsrm_pkg::ADDR_WIDTH-1:0] addr,
                   input logic [twsrm_pkg::DATA_WIDTH-1:0] wdata,
                   input logic [twsrm_pkg::DATA_WIDTH-1:0] pattern,
                   input bit busy_starts);
      tick_type t;
      t = '{1'b1, act, addr, wdata, pattern[7]};
      send_tick(t);
      while (bus_phase != BUS_IDLE) begin
         t = random_tick();
         t.start_req = busy_starts;
         t.sdio_in = pattern[bit_sel];
         send_tick(t);
      end
   endtask

   task csr_read_check(input twsrm_pkg::reg_index_type idx,
                       input logic [twsrm_pkg::CFG_WIDTH-1:0] want);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'h0, want}) begin
         $error("csr %s expected %0h got %0h", idx.name(), want, csr_prdata);
         tb_errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task set_reg(input twsrm_pkg::reg_index_type idx, input logic [twsrm_pkg::CFG_WIDTH-1:0] v);
      settle_bus();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == twsrm_pkg::REG_HALF_PERIOD)
         half_ticks = v;
      else
         turn_ticks = v;
      csr_updates++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_read_check(idx, v);
   endtask

   task set_timing(input logic [twsrm_pkg::CFG_WIDTH-1:0] half,
                   input logic [twsrm_pkg::CFG_WIDTH-1:0] turn);
      set_reg(twsrm_pkg::REG_HALF_PERIOD, half);
      set_reg(twsrm_pkg::REG_TURNAROUND, turn);
   endtask

   task test_reset_values();
      tick_type t;
      gaps_on = 1'b0;
      rsp_stalls = 1'b0;
      csr_read_check(twsrm_pkg::REG_HALF_PERIOD, twsrm_pkg::HALF_RESET);
      csr_read_check(twsrm_pkg::REG_TURNAROUND, twsrm_pkg::TURN_RESET);
      repeat (4) begin
         t = random_tick();
         t.start_req = 1'b0;
         send_tick(t);
      end
      run_access(twsrm_pkg::ACT_READ, 7'h12, 8'h00, 8'hC3, 1'b0);
      settle_bus();
   endtask

   task test_directed_frames();
      gaps_on = 1'b1;
      rsp_stalls = 1'b1;
      set_timing(16'd1, 16'd1);
      run_access(twsrm_pkg::ACT_WRITE, 7'h7F, 8'hFF, 8'h00, 1'b1);
      run_access(twsrm_pkg::ACT_READ, 7'h55, 8'hAA, 8'hA5, 1'b1);
      finish_access();
   endtask

   task test_zero_lengths();
      set_timing(16'd0, 16'd0);
      run_access(twsrm_pkg::ACT_READ, 7'h6A, 8'h00, 8'h5E, 1'b1);
      finish_access();
   endtask

   task test_random_traffic();
      int unsigned first_done;
      int unsigned first_tick;
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: set_timing(16'd1, 16'd2);
            1: set_timing(16'd0, 16'd1);
            default: set_timing(16'($urandom_range(0, 1)), 16'($urandom_range(0, 4)));
         endcase
         gaps_on = (p != 1);
         rsp_stalls = (p != 2);
         first_done = done_total;
         first_tick = tick_total;
         while (done_total - first_done < 1 || tick_total - first_tick < 30) begin
            if ($urandom_range(0, 39) == 0)
               settle_bus();
            send_tick(random_tick());
         end
         finish_access();
      end
   endtask

   initial begin
      #500_000;
      $display("two_wire_sensor_register_master_top test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.start_req = 1'b0;
      req_bus.action = twsrm_pkg::ACT_READ;
      req_bus.reg_addr = '0;
      req_bus.write_data = '0;
      req_bus.sdio_in = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_directed_frames();
      test_zero_lengths();
      test_random_traffic();

      settle_bus();
      repeat (10) @(negedge clock);
      if (expected_levels.size() != 0) begin
         $error("%0d bus levels never returned", expected_levels.size());
         tb_errors++;
      end
      $display("ran %0d ticks: %0d register reads and %0d register writes on the bus,",
               tick_total, reads_started, writes_started);
      $display("%0d completed, %0d timing updates, %0d mismatches",
               done_total, csr_updates, mismatches + tb_errors);
      if (mismatches + tb_errors == 0)
         $display("two_wire_sensor_register_master_top test passed");
      else
         $display("two_wire_sensor_register_master_top test failed");
      $finish;
   end

endmodule
